// ===== hw/rtl/text_console_char_writer_assert.svh =====
// Assertion macros used by the text console character writer RTL.
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// Shared types and constants of the text console character writer.
`timescale 1ns / 1ps

package tcw_pkg;

    // Command modes.
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Character codes with a special role.
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_ERROR   = 8'd69;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    // Register indexes on the configuration port.
    localparam logic REG_DEFAULT_ATTR = 1'b0;
    localparam logic REG_ERROR_ATTR   = 1'b1;

    // Register reset values.
    localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;
    localparam logic [7:0] ERROR_ATTR_RESET   = 8'd244;

    // One command word.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic [7:0] attr;
        logic [7:0] col;
        logic [7:0] row;
        logic       use_cursor;
    } cmd_word_t;

    // One response word.
    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic       coord_error;
        logic [7:0] read_char;
        logic [7:0] read_attr;
    } rsp_word_t;

endpackage

// ===== hw/rtl/tcw_screen_ram.sv =====
// Screen cell memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module tcw_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int DATA_W = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/text_console_char_writer.sv =====
// Text console character writer: screen store, cursor and command sequencer.
//
// Usage: commands arrive on the cmd channel (valid/ready), one word each, and
// every command returns exactly one word on the rsp channel (valid/ready).
// Mode 0 puts a character at the cursor or at a given column and row, mode 1
// clears the screen to spaces, mode 2 reads one cell. The two attribute
// registers sit on the APB-style port at byte addresses 0 and 4.
// A put, a read or an idle mode passes from acceptance through the execute and
// done states to the registered response word; a new command is taken only in idle.
// A put that runs past the last row scrolls the screen, one cell per cycle
// through the single memory read port.
// A clear writes one cell per cycle.
// Reset: the cursor goes home, the registers take their reset values and a
// clearing pass zeroes the store with cmd_ready low; register writes are
// taken throughout.
// Stalls: one finished response word waits in the output register while the
// next command is accepted; that command then waits until the slot frees.
`timescale 1ns / 1ps

`include "text_console_char_writer_assert.svh"

module text_console_char_writer #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  tcw_pkg::cmd_word_t cmd_word,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output tcw_pkg::rsp_word_t rsp_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import tcw_pkg::*;

    localparam int COL_W  = $clog2(SCREEN_COLS);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_LIMIT = ADDR_W'(CELLS - SCREEN_COLS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_COLS);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_ROWS - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_SCROLL_TAIL,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // Sequencer and datapath registers.
    state_t            state_reg, state_next;
    cmd_word_t         cmd_reg, cmd_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              err_reg, err_next;
    logic              rd_flag_reg, rd_flag_next;
    logic              copy_valid_reg, copy_valid_next;
    logic [ADDR_W-1:0] copy_addr_reg, copy_addr_next;
    logic              copy_src_reg, copy_src_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_word_t         rsp_word_reg, rsp_word_next;

    // Configuration registers.
    logic [7:0] default_attr_reg;
    logic [7:0] error_attr_reg;

    // Memory port signals.
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_rdata;

    // Target cell decode.
    logic [COL_W-1:0]  tgt_col;
    logic [ROW_W-1:0]  tgt_row;
    logic [ADDR_W-1:0] tgt_addr;
    logic              coord_bad;
    logic              is_newline;
    logic [COL_W:0]    col_inc;
    logic              line_wrap;
    logic [7:0]        attr_eff;
    logic              rsp_free;
    logic [8:0]        col_ext;
    logic [7:0]        row_ext;

    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .DATA_W (16)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Configuration port: always ready, reads return the register value.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ERROR_ATTR) ? {24'd0, error_attr_reg}
                                                 : {24'd0, default_attr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= DEFAULT_ATTR_RESET;
            error_attr_reg   <= ERROR_ATTR_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_ERROR_ATTR)
            begin
                error_attr_reg <= pwdata[7:0];
            end
            else
            begin
                default_attr_reg <= pwdata[7:0];
            end
        end
    end

    // Target cell: the cursor or the given column and row.
    always_comb
    begin
        tgt_col    = cmd_reg.use_cursor ? cur_col_reg : cmd_reg.col[COL_W-1:0];
        tgt_row    = cmd_reg.use_cursor ? cur_row_reg : cmd_reg.row[ROW_W-1:0];
        tgt_addr   = ADDR_W'(tgt_row) * ROW_STRIDE + ADDR_W'(tgt_col);
        coord_bad  = !cmd_reg.use_cursor &&
                     ((9'(cmd_reg.col) >= 9'(SCREEN_COLS)) ||
                      (9'(cmd_reg.row) >= 9'(SCREEN_ROWS)));
        is_newline = (cmd_reg.char_code == CH_NEWLINE);
        col_inc    = (COL_W+1)'(tgt_col) + 1'b1;
        line_wrap  = is_newline || (col_inc == (COL_W+1)'(SCREEN_COLS));
        attr_eff   = (cmd_reg.attr == 8'd0) ? default_attr_reg : cmd_reg.attr;
        rsp_free   = !rsp_valid_reg || rsp_ready;
        col_ext    = 9'(cur_col_reg);
        row_ext    = 8'(cur_row_reg);
    end

    // Sequencer next state, memory control and response loading.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        sweep_next      = sweep_reg;
        err_next        = err_reg;
        rd_flag_next    = rd_flag_reg;
        copy_valid_next = 1'b0;
        copy_addr_next  = copy_addr_reg;
        copy_src_next   = copy_src_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_word_next   = rsp_word_reg;

        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = 16'd0;
        mem_re    = 1'b0;
        mem_raddr = tgt_addr;

        case (state_reg)
            ST_INIT:
            begin
                // Power-up pass that zeroes every cell.
                mem_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next     = cmd_word;
                    err_next     = 1'b0;
                    rd_flag_next = 1'b0;
                    state_next   = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (cmd_reg.mode)
                    MODE_PUT:
                    begin
                        if (coord_bad)
                        begin
                            // Error marker in the last cell; the cursor stays.
                            mem_we    = 1'b1;
                            mem_waddr = LAST_CELL;
                            mem_wdata = {error_attr_reg, CH_ERROR};
                            err_next  = 1'b1;
                        end
                        else
                        begin
                            mem_we    = !is_newline;
                            mem_waddr = tgt_addr;
                            mem_wdata = {attr_eff, cmd_reg.char_code};
                            cur_row_next = tgt_row;
                            if (line_wrap)
                            begin
                                cur_col_next = '0;
                                if (tgt_row == LAST_ROW)
                                begin
                                    sweep_next = '0;
                                    state_next = ST_SCROLL;
                                end
                                else
                                begin
                                    cur_row_next = tgt_row + 1'b1;
                                end
                            end
                            else
                            begin
                                cur_col_next = col_inc[COL_W-1:0];
                            end
                        end
                    end

                    MODE_CLEAR:
                    begin
                        cur_col_next = '0;
                        cur_row_next = '0;
                        sweep_next   = '0;
                        state_next   = ST_CLEAR;
                    end

                    MODE_READ:
                    begin
                        if (coord_bad)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            mem_re       = 1'b1;
                            rd_flag_next = 1'b1;
                        end
                    end

                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_SCROLL:
            begin
                // Read the cell one row down and write it in the following cycle;
                // the last row gets zeros.
                mem_re          = (sweep_reg < COPY_LIMIT);
                mem_raddr       = sweep_reg + ROW_STRIDE;
                mem_we          = copy_valid_reg;
                mem_waddr       = copy_addr_reg;
                mem_wdata       = copy_src_reg ? mem_rdata : 16'd0;
                copy_valid_next = 1'b1;
                copy_addr_next  = sweep_reg;
                copy_src_next   = (sweep_reg < COPY_LIMIT);
                sweep_next      = sweep_reg + 1'b1;
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = ST_SCROLL_TAIL;
                end
            end

            ST_SCROLL_TAIL:
            begin
                // Drain the last pending write of the scroll.
                mem_we     = copy_valid_reg;
                mem_waddr  = copy_addr_reg;
                mem_wdata  = copy_src_reg ? mem_rdata : 16'd0;
                state_next = ST_DONE;
            end

            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {default_attr_reg, CH_SPACE};
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Load the response word once the output slot is free.
                if (rsp_free)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_word_next.cursor_col = col_ext[6:0];
                    rsp_word_next.cursor_row = row_ext[4:0];
                    rsp_word_next.coord_error = err_reg;
                    rsp_word_next.read_char  = rd_flag_reg ? mem_rdata[7:0] : 8'd0;
                    rsp_word_next.read_attr  = rd_flag_reg ? mem_rdata[15:8] : 8'd0;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            cmd_reg        <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            sweep_reg      <= '0;
            err_reg        <= 1'b0;
            rd_flag_reg    <= 1'b0;
            copy_valid_reg <= 1'b0;
            copy_addr_reg  <= '0;
            copy_src_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_word_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            sweep_reg      <= sweep_next;
            err_reg        <= err_next;
            rd_flag_reg    <= rd_flag_next;
            copy_valid_reg <= copy_valid_next;
            copy_addr_reg  <= copy_addr_next;
            copy_src_reg   <= copy_src_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_word_reg   <= rsp_word_next;
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // Checks on the sequencer and memory traffic.
    `TCW_ASSERT_NOW(a_cursor_in_range, 1'b1, ((COL_W+1)'(cur_col_reg) < (COL_W+1)'(SCREEN_COLS)) && ((ROW_W+1)'(cur_row_reg) < (ROW_W+1)'(SCREEN_ROWS)), "cursor left the screen")
    `TCW_ASSERT_NOW(a_no_same_cell_rw, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit one cell in one cycle")
    `TCW_ASSERT_NOW(a_exec_after_accept, state_reg == ST_EXEC, $past(cmd_valid && cmd_ready), "command executed without acceptance")
    `TCW_ASSERT_NOW(a_copy_only_in_scroll, copy_valid_reg, (state_reg == ST_SCROLL) || (state_reg == ST_SCROLL_TAIL), "scroll write pending outside scroll")
    `TCW_ASSERT_NEXT(a_done_loads_rsp, (state_reg == ST_DONE) && rsp_free, rsp_valid_reg && (state_reg == ST_IDLE), "response word not loaded")

endmodule

// ===== dv/tb_text_console_char_writer.sv =====
// Self-checking testbench for the text console character writer.
`timescale 1ns / 1ps

module tb_text_console_char_writer;

    import tcw_pkg::*;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
    localparam int RANDOM_PHASES = 6;
    localparam int WORDS_PER_PHASE = 255;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    cmd_word_t   cmd_word = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_word_t   rsp_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the console: screen cells, cursor and both attribute registers.
    logic [15:0] shadow_cells [CELL_COUNT];
    int          shadow_cursor;
    logic [7:0]  shadow_default_attr;
    logic [7:0]  shadow_error_attr;
    bit          last_was_full_pass;

    cmd_word_t   pending_cmd_q [$];
    rsp_word_t   expected_rsp_q [$];
    rsp_word_t   oldest_rsp;

    int          issued_count = 0;
    int          accepted_count = 0;
    int          checked_count = 0;
    int          mismatch_count = 0;
    longint      cycle_count = 0;
    longint      cycle_limit = 100000;

    int          send_burst = 1;
    int          send_gap = 0;
    int          rsp_pattern = 0;
    int          holdoff_left = 0;
    int          holdoff_index = 0;

    text_console_char_writer #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd_word(cmd_word),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_word(rsp_word),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one command word to the shadow console and return the response it should give.
    function automatic rsp_word_t console_apply(cmd_word_t c);
        rsp_word_t  r;
        logic [7:0] at;
        logic       bad;
        int         pos;
        int         i;
        r = '0;
        at = c.attr;
        bad = !c.use_cursor && (c.col >= SCREEN_COLS || c.row >= SCREEN_ROWS);
        pos = c.use_cursor ? shadow_cursor : int'(c.row) * SCREEN_COLS + int'(c.col);
        last_was_full_pass = 1'b0;
        case (c.mode)
            MODE_PUT:
            begin
                if (at == 8'd0)
                    at = shadow_default_attr;
                if (bad)
                begin
                    // Out-of-range target: error marker in the last cell, cursor stays.
                    shadow_cells[CELL_COUNT - 1] = {shadow_error_attr, CH_ERROR};
                    r.coord_error = 1'b1;
                end
                else
                begin
                    if (pos >= CELL_COUNT)
                        pos = 0;
                    if (c.char_code == CH_NEWLINE)
                        pos = (pos / SCREEN_COLS + 1) * SCREEN_COLS;
                    else
                    begin
                        shadow_cells[pos] = {at, c.char_code};
                        pos = pos + 1;
                    end
                    // Running off the end scrolls up one row and blanks the last one.
                    if (pos >= CELL_COUNT)
                    begin
                        for (i = 0; i + SCREEN_COLS < CELL_COUNT; i++)
                            shadow_cells[i] = shadow_cells[i + SCREEN_COLS];
                        for (i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++)
                            shadow_cells[i] = 16'd0;
                        pos = pos - SCREEN_COLS;
                        last_was_full_pass = 1'b1;
                    end
                    shadow_cursor = pos;
                end
            end
            MODE_CLEAR:
            begin
                for (i = 0; i < CELL_COUNT; i++)
                    shadow_cells[i] = {shadow_default_attr, CH_SPACE};
                shadow_cursor = 0;
                last_was_full_pass = 1'b1;
            end
            MODE_READ:
            begin
                if (bad)
                    r.coord_error = 1'b1;
                else if (pos < CELL_COUNT)
                    {r.read_attr, r.read_char} = shadow_cells[pos];
            end
            default:
            begin
            end
        endcase
        r.cursor_col = 7'(shadow_cursor % SCREEN_COLS);
        r.cursor_row = 5'(shadow_cursor / SCREEN_COLS);
        return r;
    endfunction

    function automatic cmd_word_t make_cmd(logic [1:0] mode, logic [7:0] ch, logic [7:0] at,
                                           logic [7:0] col, logic [7:0] row, logic uc);
        cmd_word_t c;
        c.mode = mode;
        c.char_code = ch;
        c.attr = at;
        c.col = col;
        c.row = row;
        c.use_cursor = uc;
        return c;
    endfunction

    // Random command: mostly in-range puts and reads, with some clears,
    // idle modes, bad coordinates and traffic aimed at the last row.
    function automatic cmd_word_t random_cmd();
        cmd_word_t c;
        int        pick;
        int        aim;
        pick = $urandom_range(0, 999);
        aim = $urandom_range(0, 99);
        c.char_code = ($urandom_range(0, 99) < 12) ? CH_NEWLINE : 8'($urandom);
        c.attr = ($urandom_range(0, 99) < 20) ? 8'd0 : 8'($urandom);
        if (aim < 8)
        begin
            c.col = 8'($urandom);
            c.row = 8'($urandom);
        end
        else if (aim < 22)
        begin
            c.col = 8'($urandom_range(SCREEN_COLS - 10, SCREEN_COLS - 1));
            c.row = 8'(SCREEN_ROWS - 1);
        end
        else
        begin
            c.col = 8'($urandom_range(0, SCREEN_COLS - 1));
            c.row = 8'($urandom_range(0, SCREEN_ROWS - 1));
        end
        if (pick < 20)
            c.mode = MODE_CLEAR;
        else if (pick < 40)
            c.mode = MODE_NONE;
        else if (pick < 200)
            c.mode = MODE_READ;
        else
            c.mode = MODE_PUT;
        c.use_cursor = ($urandom_range(0, 99) < 60);
        return c;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at response %0d, %s: got 0x%0h, expected 0x%0h",
                 checked_count, field, got, want);
        mismatch_count++;
    endtask

    task automatic push_cmd(cmd_word_t c);
        pending_cmd_q.push_back(c);
        issued_count++;
    endtask

    // Wait until every issued word has been answered, then let the block settle.
    task automatic wait_for_drain();
        while (checked_count != issued_count)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic reg_write(logic reg_index, logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_index, 2'b00};
        pwdata <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_index == REG_DEFAULT_ATTR)
            shadow_default_attr = value;
        else
            shadow_error_attr = value;
    endtask

    // Command driver: bursts of words separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (!cmd_valid || cmd_ready)
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                cmd_valid <= 1'b0;
            end
            else if (pending_cmd_q.size() != 0)
            begin
                cmd_word <= pending_cmd_q.pop_front();
                cmd_valid <= 1'b1;
                if (send_burst <= 1)
                begin
                    send_burst = $urandom_range(1, 48);
                    case ($urandom_range(0, 19))
                        0: send_gap = $urandom_range(20, 40);
                        1, 2, 3, 4, 5: send_gap = $urandom_range(4, 12);
                        default: send_gap = $urandom_range(0, 3);
                    endcase
                end
                else
                    send_burst = send_burst - 1;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // Response receiver: a stall pattern that is re-chosen at random, plus two long
    // hold-offs that back the block up into its input.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (holdoff_left > 0)
        begin
            holdoff_left = holdoff_left - 1;
            rsp_ready <= 1'b0;
        end
        else if ((holdoff_index == 0 && accepted_count >= 400) ||
                 (holdoff_index == 1 && accepted_count >= 1100))
        begin
            holdoff_index = holdoff_index + 1;
            holdoff_left = 300;
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (cycle_count % 64 == 0)
                rsp_pattern = $urandom_range(0, 3);
            case (rsp_pattern)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= 1'($urandom_range(0, 1));
                2: rsp_ready <= (cycle_count % 4 == 0);
                default: rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Monitor: predict on each accepted command word, check each accepted response word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                expected_rsp_q.push_back(console_apply(cmd_word));
                accepted_count++;
                cycle_limit += last_was_full_pass ? 4 * 2200 : 4 * 120;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                    report("word with nothing expected", 32'(rsp_word), 32'd0);
                else
                begin
                    oldest_rsp = expected_rsp_q.pop_front();
                    if (rsp_word.cursor_col !== oldest_rsp.cursor_col)
                        report("cursor_col", 32'(rsp_word.cursor_col),
                               32'(oldest_rsp.cursor_col));
                    if (rsp_word.cursor_row !== oldest_rsp.cursor_row)
                        report("cursor_row", 32'(rsp_word.cursor_row),
                               32'(oldest_rsp.cursor_row));
                    if (rsp_word.coord_error !== oldest_rsp.coord_error)
                        report("coord_error", 32'(rsp_word.coord_error),
                               32'(oldest_rsp.coord_error));
                    if (rsp_word.read_char !== oldest_rsp.read_char)
                        report("read_char", 32'(rsp_word.read_char),
                               32'(oldest_rsp.read_char));
                    if (rsp_word.read_attr !== oldest_rsp.read_attr)
                        report("read_attr", 32'(rsp_word.read_attr),
                               32'(oldest_rsp.read_attr));
                end
                checked_count++;
            end
        end
    end

    // Watchdog: the limit grows with every accepted word.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus: reset, a directed phase, then random phases under changing attributes.
    initial
    begin
        int phase;
        int n;
        for (n = 0; n < CELL_COUNT; n++)
            shadow_cells[n] = 16'd0;
        shadow_cursor = 0;
        shadow_default_attr = DEFAULT_ATTR_RESET;
        shadow_error_attr = ERROR_ATTR_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset attributes.
        push_cmd(make_cmd(MODE_PUT, "A", 8'd0, 8'd0, 8'd0, 1'b1));
        push_cmd(make_cmd(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
        push_cmd(make_cmd(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        // A put in the last cell scrolls the screen.
        push_cmd(make_cmd(MODE_PUT, 8'hFF, 8'hFF, 8'd79, 8'd24, 1'b0));
        push_cmd(make_cmd(MODE_READ, 8'd0, 8'd0, 8'd79, 8'd23, 1'b0));
        push_cmd(make_cmd(MODE_READ, 8'd0, 8'd0, 8'd79, 8'd24, 1'b0));
        // Bad coordinates on puts and reads.
        push_cmd(make_cmd(MODE_PUT, "x", 8'd7, 8'd80, 8'd0, 1'b0));
        push_cmd(make_cmd(MODE_READ, 8'd0, 8'd0, 8'd79, 8'd24, 1'b0));
        push_cmd(make_cmd(MODE_PUT, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0));
        push_cmd(make_cmd(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd25, 1'b0));
        push_cmd(make_cmd(MODE_READ, 8'hFF, 8'hFF, 8'd255, 8'd255, 1'b0));
        // Newline on the last row scrolls; a newline elsewhere only moves.
        push_cmd(make_cmd(MODE_PUT, CH_NEWLINE, 8'd0, 8'd0, 8'd0, 1'b1));
        push_cmd(make_cmd(MODE_PUT, CH_NEWLINE, 8'hFF, 8'd5, 8'd3, 1'b0));
        push_cmd(make_cmd(MODE_PUT, 8'd0, 8'd1, 8'd0, 8'd0, 1'b1));
        push_cmd(make_cmd(MODE_PUT, "Z", 8'h80, 8'd255, 8'd255, 1'b1));
        push_cmd(make_cmd(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd4, 1'b0));
        // Unused mode, then a clear with junk coordinates.
        push_cmd(make_cmd(MODE_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        push_cmd(make_cmd(MODE_CLEAR, 8'hFF, 8'hFF, 8'd255, 8'd255, 1'b0));
        push_cmd(make_cmd(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        push_cmd(make_cmd(MODE_READ, 8'd0, 8'd0, 8'd79, 8'd24, 1'b0));
        push_cmd(make_cmd(MODE_PUT, "q", 8'd0, 8'd0, 8'd0, 1'b1));
        push_cmd(make_cmd(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));

        for (phase = 1; phase <= RANDOM_PHASES; phase++)
        begin
            wait_for_drain();
            case (phase)
                1:
                begin
                    reg_write(REG_DEFAULT_ATTR, 8'd0);
                    reg_write(REG_ERROR_ATTR, 8'd255);
                end
                2:
                begin
                    reg_write(REG_DEFAULT_ATTR, 8'd255);
                    reg_write(REG_ERROR_ATTR, 8'd0);
                end
                default:
                begin
                    reg_write(REG_DEFAULT_ATTR, 8'($urandom));
                    reg_write(REG_ERROR_ATTR, 8'($urandom));
                end
            endcase
            for (n = 0; n < WORDS_PER_PHASE; n++)
                push_cmd(random_cmd());
        end

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (expected_rsp_q.size() != 0)
            report("words still expected", expected_rsp_q.size(), 32'd0);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
